### hw/rtl/rle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_pkg: shared definitions for the run-length expander
// Constants, controller states and the command and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package rle_pkg;

  // Largest repeat count. Must stay within 2..64 so that it fits CountW bits.
  localparam int MaxRun = 64;
  localparam int CountW = 7;
  localparam int CharW  = 8;
  localparam int LetterW = 7;

  // ASCII ranges for digits and uppercase letters.
  localparam logic [CharW-1:0] CharZero = 8'h30;
  localparam logic [CharW-1:0] CharNine = 8'h39;
  localparam logic [CharW-1:0] CharA    = 8'h41;
  localparam logic [CharW-1:0] CharZ    = 8'h5A;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic acc_digit;    // fold the input digit into the pending count
    logic load_letter;  // capture the letter, load the copy counter, clear count
    logic dec;          // one copy was transferred
  } dp_cmd_t;

  typedef struct packed {
    logic is_digit;
    logic is_letter;
    logic run_zero;     // the letter on the input would emit no copies
    logic remain_one;   // the copy on the output is the last of its run
  } dp_status_t;

endpackage

### hw/rtl/rle_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_datapath: count accumulator and copy counter
// Classifies the input byte, builds the saturating decimal count and holds
// the letter and the number of copies still to send.
// ----------------------------------------------------------------------------
module rle_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [rle_pkg::CharW-1:0]   char_in,
  input  rle_pkg::dp_cmd_t            cmd,
  output rle_pkg::dp_status_t         status,
  output logic [rle_pkg::LetterW-1:0] letter_out,
  output logic                        last_of_run
);

  localparam int AccW = rle_pkg::CountW + 4;

  logic [rle_pkg::CountW-1:0]  count_r, count_nxt;
  logic                        have_r, have_nxt;
  logic [rle_pkg::LetterW-1:0] letter_r;
  logic [rle_pkg::CountW-1:0]  remain_r;
  logic [rle_pkg::CountW-1:0]  run_len;
  logic [AccW-1:0]             acc;

  always_comb begin
    status.is_digit  = (char_in >= rle_pkg::CharZero) && (char_in <= rle_pkg::CharNine);
    status.is_letter = (char_in >= rle_pkg::CharA) && (char_in <= rle_pkg::CharZ);
    run_len = have_r ? count_r : rle_pkg::CountW'(1);
    status.run_zero   = (run_len == '0);
    status.remain_one = (remain_r == rle_pkg::CountW'(1));
  end

  // The count never exceeds MaxRun, so count*10+9 fits AccW bits.
  always_comb begin
    acc = AccW'(count_r) * AccW'(10) + AccW'(char_in[3:0]);
    count_nxt = count_r;
    have_nxt  = have_r;
    if (cmd.acc_digit) begin
      have_nxt = 1'b1;
      if (acc > AccW'(rle_pkg::MaxRun)) begin
        count_nxt = rle_pkg::CountW'(rle_pkg::MaxRun);
      end else begin
        count_nxt = acc[rle_pkg::CountW-1:0];
      end
    end else if (cmd.load_letter) begin
      count_nxt = '0;
      have_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      have_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      have_r  <= have_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_letter) begin
      letter_r <= char_in[rle_pkg::LetterW-1:0];
      remain_r <= run_len;
    end else if (cmd.dec) begin
      remain_r <= remain_r - rle_pkg::CountW'(1);
    end
  end

  assign letter_out  = letter_r;
  assign last_of_run = status.remain_one;

endmodule

### hw/rtl/rle_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_ctrl: sequencing state machine
// Accepts bytes while idle and holds the block in the emit state while the
// copies of a run are transferred.
// ----------------------------------------------------------------------------
module rle_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  rle_pkg::dp_status_t status,
  output rle_pkg::dp_cmd_t    cmd
);

  rle_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rle_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      rle_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.acc_digit   = status.is_digit;
          cmd.load_letter = status.is_letter;
          if (status.is_letter && !status.run_zero) begin
            state_nxt = rle_pkg::ST_EMIT;
          end
        end
      end
      rle_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.dec = 1'b1;
          if (status.remain_one) begin
            state_nxt = rle_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = rle_pkg::ST_IDLE;
    endcase
  end

endmodule

### hw/rtl/run_length_expander_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// run_length_expander_core: run-length text expander
// Expands a packed text of decimal counts and uppercase letters into runs.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_ready, in_char_in) carries one byte of
//   packed text per transfer. Digits build a pending decimal count that
//   saturates at the package limit. An uppercase letter produces that many
//   copies on the output channel (out_valid, out_ready, out_letter_out,
//   out_last_of_run), or one copy when no digit came before it; the final
//   copy of each run has out_last_of_run set. A count of zero produces
//   nothing. Any other byte is dropped and leaves the pending count alone.
//   Timing: after a digit or an ignored byte the block is ready again in the
//   next cycle. When a letter is accepted, its first copy is presented in the
//   following cycle and each further copy follows in the cycle after the
//   previous transfer. The single copy counter serves one run at a time, so
//   in_ready is low while a run is being sent.
//   Reset clears the pending count and returns to idle. If the receiver
//   stalls, the current copy is held stable on the output until taken.
// ----------------------------------------------------------------------------
module run_length_expander_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [rle_pkg::CharW-1:0]   in_char_in,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rle_pkg::LetterW-1:0] out_letter_out,
  output logic                        out_last_of_run
);

  // Commands from the controller and status from the datapath.
  rle_pkg::dp_cmd_t    cmd;
  rle_pkg::dp_status_t status;

  // The controller owns both handshakes; the datapath never sees valid or
  // ready, only the commands that result from a transfer.
  rle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath's letter and copy counter registers drive the output
  // payload directly, so the payload holds while the receiver stalls.
  rle_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .char_in     (in_char_in),
    .cmd         (cmd),
    .status      (status),
    .letter_out  (out_letter_out),
    .last_of_run (out_last_of_run)
  );

endmodule
